// ===== rtl/rrcw_pkg.sv =====
// Shared types and constants for the radial ripple coordinate warp.
// Fixed-point formats, register codes and pipeline side-band structs.
// No dependencies.
package rrcw_pkg;

  localparam int MAX_DIM   = 8192;
  localparam int FRAC_BITS = 8;

  localparam int PIX_W   = 13;
  localparam int COORD_W = PIX_W + FRAC_BITS;     // pixel center in sub-pixel units
  localparam int D_W     = COORD_W + 2;           // signed offset from ripple center
  localparam int MAG_W   = COORD_W;               // |dx|, |dy|
  localparam int RP_W    = MAG_W + 1;             // floor(sqrt(dx^2 + dy^2))
  localparam int SQ_W    = 2 * RP_W;
  localparam int PIX_HALF = 1 << (FRAC_BITS - 1);
  localparam int OUT_W   = 23;

  localparam int OUT_LOW  = -131072;
  localparam int OUT_HIGH = 2228224;

  // Q16 angle and exp constants
  localparam int Q16_ONE     = 65536;
  localparam int Q16_TWO_PI  = 411775;
  localparam int Q16_PI      = 205887;
  localparam int Q16_HALF_PI = 102944;
  localparam int Q16_LOG2E   = 94548;
  localparam int Q16_LN2     = 45426;

  // exact reciprocal multipliers for small constant divisors
  localparam int RCP42_S = 399458;  localparam int SH42_S = 24;  // 18-bit dividend
  localparam int RCP20_S = 419431;  localparam int SH20_S = 23;
  localparam int RCP6_S  = 349526;  localparam int SH6_S  = 21;
  localparam int RCP6_F  = 87382;   localparam int SH6_F  = 19;  // 16-bit dividend
  localparam int RCP5_F  = 104858;  localparam int SH5_F  = 19;
  localparam int RCP3_F  = 87382;   localparam int SH3_F  = 18;

  localparam int E_CAP     = 1 << 20;   // any e at or above this fades to zero
  localparam int FADE_NMAX = 17;

  localparam int RST_CENTER_X  = 1048576;
  localparam int RST_CENTER_Y  = 1048576;
  localparam int RST_INV_HALF  = 4096;
  localparam int RST_AMP       = 20972;
  localparam int RST_FREQUENCY = 3072;
  localparam int RST_PHASE     = 0;
  localparam int RST_DECAY     = 256;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_INV_HALF   = 3'd2,
    REG_AMP        = 3'd3,
    REG_FREQUENCY  = 3'd4,
    REG_RING_PHASE = 3'd5,
    REG_DECAY_RATE = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic             dx_neg;
    logic             dy_neg;
    logic [MAG_W-1:0] dx_mag;
    logic [MAG_W-1:0] dy_mag;
  } geo_t;

  typedef struct packed {
    geo_t            geo;
    logic [RP_W-1:0] rp;
    logic [34:0]     e;
  } mside_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             flip;
    logic             zero;
  } coord_t;

endpackage

// ===== rtl/rrcw_isqrt.sv =====
// Pipelined integer square root, two result bits per stage.
// Carries a valid bit and an opaque side-band word alongside. No package use.
module rrcw_isqrt #(
  parameter int RW = 22,
  parameter int SW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [2*RW-1:0]   rad_i,
  input  logic [SW-1:0]     side_i,
  output logic              vld_o,
  output logic [RW-1:0]     root_o,
  output logic [SW-1:0]     side_o
);

  localparam int VW = 2 * RW;
  localparam int NS = (RW + 1) / 2;

  logic [NS-1:0] vld_q;
  logic [VW-1:0] v_q   [NS];
  logic [VW-1:0] res_q [NS];
  logic [SW-1:0] sd_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int I0 = 2 * s;
    localparam int I1 = 2 * s + 1;
    localparam logic [VW-1:0] B0 = VW'(1) << (2 * (RW - 1 - I0));

    logic [VW-1:0] v_in, r_in, v_mid, r_mid, v_out, r_out;
    logic [SW-1:0] sd_in;
    logic          vld_in;

    if (s == 0) begin : g_first
      assign v_in   = rad_i;
      assign r_in   = '0;
      assign sd_in  = side_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign r_in   = res_q[s-1];
      assign sd_in  = sd_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    always_comb begin
      v_mid = v_in;
      r_mid = r_in >> 1;
      if (v_in >= r_in + B0) begin
        v_mid = v_in - (r_in + B0);
        r_mid = (r_in >> 1) + B0;
      end
    end

    if (I1 < RW) begin : g_two
      localparam logic [VW-1:0] B1 = VW'(1) << (2 * (RW - 1 - I1));
      always_comb begin
        v_out = v_mid;
        r_out = r_mid >> 1;
        if (v_mid >= r_mid + B1) begin
          v_out = v_mid - (r_mid + B1);
          r_out = (r_mid >> 1) + B1;
        end
      end
    end else begin : g_one
      assign v_out = v_mid;
      assign r_out = r_mid;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      v_q[s]   <= v_out;
      res_q[s] <= r_out;
      sd_q[s]  <= sd_in;
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign root_o = RW'(res_q[NS-1]);
  assign side_o = sd_q[NS-1];

endmodule

// ===== rtl/rrcw_div.sv =====
// Pipelined restoring divider, two quotient bits per stage.
// Needs dividend < divisor << QW. Carries valid and a side-band word. No package use.
module rrcw_div #(
  parameter int DW = 38,
  parameter int VW = 22,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quot_o,
  output logic [VW-1:0] rem_o,
  output logic [SW-1:0] side_o
);

  localparam int NS = (QW + 1) / 2;
  localparam int W  = (DW > VW + QW) ? DW : VW + QW;

  logic [NS-1:0] vld_q;
  logic [W-1:0]  rem_q [NS];
  logic [QW-1:0] quo_q [NS];
  logic [VW-1:0] dv_q  [NS];
  logic [SW-1:0] sd_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int K0 = QW - 1 - 2 * s;
    localparam int K1 = K0 - 1;

    logic [W-1:0]  rem_in, rem_mid, rem_out, sh0;
    logic [QW-1:0] q_in, q_mid, q_out;
    logic [VW-1:0] dv_in;
    logic [SW-1:0] sd_in;
    logic          vld_in;

    if (s == 0) begin : g_first
      assign rem_in = W'(dividend_i);
      assign q_in   = '0;
      assign dv_in  = divisor_i;
      assign sd_in  = side_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign q_in   = quo_q[s-1];
      assign dv_in  = dv_q[s-1];
      assign sd_in  = sd_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    assign sh0 = W'(dv_in) << K0;

    always_comb begin
      rem_mid = rem_in;
      q_mid   = q_in;
      if (rem_in >= sh0) begin
        rem_mid   = rem_in - sh0;
        q_mid[K0] = 1'b1;
      end
    end

    if (K1 >= 0) begin : g_two
      logic [W-1:0] sh1;
      assign sh1 = W'(dv_in) << K1;
      always_comb begin
        rem_out = rem_mid;
        q_out   = q_mid;
        if (rem_mid >= sh1) begin
          rem_out   = rem_mid - sh1;
          q_out[K1] = 1'b1;
        end
      end
    end else begin : g_one
      assign rem_out = rem_mid;
      assign q_out   = q_mid;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_out;
      quo_q[s] <= q_out;
      dv_q[s]  <= dv_in;
      sd_q[s]  <= sd_in;
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign quot_o = quo_q[NS-1];
  assign rem_o  = VW'(rem_q[NS-1]);
  assign side_o = sd_q[NS-1];

endmodule

// ===== rtl/radial_ripple_coordinate_warp_core.sv =====
// Top level of the radial ripple coordinate warp: config registers and the full pipeline.
// Depends on rrcw_pkg, rrcw_isqrt and rrcw_div.
//
//  channel   signals                                   direction  beat taken when
//  pixel     start, busy, pixel_x_i, pixel_y_i         in         start && !busy
//  result    result_valid_o, source_x_o, source_y_o    out        result_valid_o (one cycle)
//  config    cfg_valid_i, cfg_ready_o, cfg_index_i,    in         cfg_valid_i && cfg_ready_o
//            cfg_data_i
//
// One pixel per clock through 52 register stages. The depth is set by the root (11 stages),
// the phase modulo (10), the sine/exp polynomials (16) and the offset dividers (9), plus 6
// stages of setup and output. busy is never raised. Reset clears the valid chain and loads
// the register defaults. The receiver cannot stall, so the pipeline only ever advances.
module radial_ripple_coordinate_warp_core
  import rrcw_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [PIX_W-1:0]        pixel_x_i,
  input  logic [PIX_W-1:0]        pixel_y_i,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [2:0]              cfg_index_i,
  input  logic [25:0]             cfg_data_i,
  output logic                    result_valid_o,
  output logic signed [OUT_W-1:0] source_x_o,
  output logic signed [OUT_W-1:0] source_y_o
);

  localparam int FN = 16;  // polynomial section depth

  typedef struct packed {
    geo_t            geo;
    logic [RP_W-1:0] rp;
    logic [34:0]     e;
    logic [18:0]     ang;
    logic            neg;
    logic [16:0]     x;
    logic [17:0]     x2;
    logic [16:0]     ts;
    logic [17:0]     ps;
    logic [16:0]     s;
    logic [21:0]     y;
    logic [5:0]      n;
    logic [15:0]     z;
    logic [16:0]     tf;
    logic [15:0]     pf;
    logic [16:0]     mf;
    logic [33:0]     amp_s;
    logic [16:0]     disp;
    logic [37:0]     numx;
    logic [37:0]     numy;
  } work_t;

  // (a * t) >> 16, one Horner multiply
  function automatic logic [17:0] mul_q16(logic [17:0] a, logic [16:0] t);
    logic [34:0] p;
    p = 35'(a) * 35'(t);
    return p[33:16];
  endfunction

  function automatic logic [16:0] one_minus(logic [17:0] q);
    return 17'(Q16_ONE) - q[16:0];
  endfunction

  // ---------------- configuration ----------------
  logic [20:0] center_x_q, center_y_q;
  logic [25:0] inv_half_q;
  logic [16:0] amp_q;
  logic [13:0] frequency_q;
  logic [18:0] ring_phase_q, ph_red_q;
  logic [10:0] decay_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= 21'(RST_CENTER_X);
      center_y_q   <= 21'(RST_CENTER_Y);
      inv_half_q   <= 26'(RST_INV_HALF);
      amp_q        <= 17'(RST_AMP);
      frequency_q  <= 14'(RST_FREQUENCY);
      ring_phase_q <= 19'(RST_PHASE);
      decay_q      <= 11'(RST_DECAY);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CENTER_X:   center_x_q   <= cfg_data_i[20:0];
        REG_CENTER_Y:   center_y_q   <= cfg_data_i[20:0];
        REG_INV_HALF:   inv_half_q   <= cfg_data_i;
        REG_AMP:        amp_q        <= cfg_data_i[16:0];
        REG_FREQUENCY:  frequency_q  <= cfg_data_i[13:0];
        REG_RING_PHASE: ring_phase_q <= cfg_data_i[18:0];
        REG_DECAY_RATE: decay_q      <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // phase folded to [0, 2pi); user keeps config static while pixels are in flight, unchecked
  always_ff @(posedge clk_i) begin
    ph_red_q <= (ring_phase_q >= 19'(Q16_TWO_PI)) ? ring_phase_q - 19'(Q16_TWO_PI)
                                                   : ring_phase_q;
  end

  // ---------------- stage A: offsets ----------------
  logic             in_beat;
  logic [PIX_W-1:0] px_cl, py_cl;
  logic [COORD_W-1:0] pcx, pcy;
  logic             a_vld_q;
  logic [PIX_W-1:0] a_px_q, a_py_q;
  logic [D_W-1:0]   a_dx_q, a_dy_q;

  assign in_beat = start && !busy;
  assign px_cl = (pixel_x_i > PIX_W'(MAX_DIM - 1)) ? PIX_W'(MAX_DIM - 1) : pixel_x_i;
  assign py_cl = (pixel_y_i > PIX_W'(MAX_DIM - 1)) ? PIX_W'(MAX_DIM - 1) : pixel_y_i;
  assign pcx = COORD_W'({px_cl, {FRAC_BITS{1'b0}}}) + COORD_W'(PIX_HALF);
  assign pcy = COORD_W'({py_cl, {FRAC_BITS{1'b0}}}) + COORD_W'(PIX_HALF);

  // ---------------- stage B: squares ----------------
  logic [MAG_W-1:0] magx, magy;
  logic             b_vld_q;
  geo_t             b_geo_q;
  logic [2*MAG_W-1:0] b_sqx_q, b_sqy_q;

  assign magx = a_dx_q[D_W-1] ? MAG_W'(-a_dx_q) : MAG_W'(a_dx_q);
  assign magy = a_dy_q[D_W-1] ? MAG_W'(-a_dy_q) : MAG_W'(a_dy_q);

  // ---------------- stage C: sum ----------------
  logic            c_vld_q;
  geo_t            c_geo_q;
  logic [SQ_W-1:0] c_sum_q;

  // ---------------- root ----------------
  logic            s_vld;
  geo_t            s_geo;
  logic [RP_W-1:0] s_rp;

  // ---------------- stage D/E ----------------
  logic [47:0]     p_r;
  logic            d_vld_q;
  geo_t            d_geo_q;
  logic [RP_W-1:0] d_rp_q;
  logic [31:0]     d_r_q;
  logic [45:0]     p_fr;
  logic [42:0]     p_e;
  logic            e_vld_q;
  mside_t          e_side_q, e_side_d;
  logic [37:0]     e_fr_q;

  assign p_r  = 48'(s_rp) * 48'(inv_half_q);
  assign p_fr = 46'(frequency_q) * 46'(d_r_q);
  assign p_e  = 43'(decay_q) * 43'(d_r_q);

  always_comb begin
    e_side_d.geo = d_geo_q;
    e_side_d.rp  = d_rp_q;
    e_side_d.e   = p_e[42:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_beat;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= s_vld;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_px_q <= px_cl;
    a_py_q <= py_cl;
    a_dx_q <= D_W'(pcx) - D_W'(center_x_q);
    a_dy_q <= D_W'(pcy) - D_W'(center_y_q);

    b_geo_q.px     <= a_px_q;
    b_geo_q.py     <= a_py_q;
    b_geo_q.dx_neg <= a_dx_q[D_W-1];
    b_geo_q.dy_neg <= a_dy_q[D_W-1];
    b_geo_q.dx_mag <= magx;
    b_geo_q.dy_mag <= magy;
    b_sqx_q <= (2*MAG_W)'(magx) * (2*MAG_W)'(magx);
    b_sqy_q <= (2*MAG_W)'(magy) * (2*MAG_W)'(magy);

    c_geo_q <= b_geo_q;
    c_sum_q <= SQ_W'(b_sqx_q) + SQ_W'(b_sqy_q);

    d_geo_q <= s_geo;
    d_rp_q  <= s_rp;
    d_r_q   <= 32'(p_r >> (FRAC_BITS + 8));

    e_side_q <= e_side_d;
    e_fr_q   <= p_fr[45:8];
  end

  rrcw_isqrt #(
    .RW (RP_W),
    .SW ($bits(geo_t))
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (c_vld_q),
    .rad_i  (c_sum_q),
    .side_i (c_geo_q),
    .vld_o  (s_vld),
    .root_o (s_rp),
    .side_o (s_geo)
  );

  // ---------------- phase modulo ----------------
  logic        m_vld;
  logic [18:0] m_rem;
  mside_t      m_side;

  rrcw_div #(
    .DW (38),
    .VW (19),
    .QW (20),
    .SW ($bits(mside_t))
  ) u_phase_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (e_vld_q),
    .dividend_i (e_fr_q),
    .divisor_i  (19'(Q16_TWO_PI)),
    .side_i     (e_side_q),
    .vld_o      (m_vld),
    .quot_o     (),
    .rem_o      (m_rem),
    .side_o     (m_side)
  );

  // ---------------- sine and fade polynomials ----------------
  work_t       wk_d [FN];
  work_t       wk_q [FN];
  logic [FN-1:0] wk_vld_q;

  always_comb begin
    logic [19:0] ang_t;
    logic [20:0] ec;
    logic [37:0] p_y;
    logic [18:0] a;
    logic [31:0] p_z;
    logic [33:0] p_xx;
    logic [33:0] p_c16;
    logic [36:0] p_c18;
    logic [33:0] p_xs;
    logic [16:0] t_end;
    logic [50:0] p_d;

    // F1: angle in [0, 2pi), exp argument in log2 units
    wk_d[0]     = '0;
    wk_d[0].geo = m_side.geo;
    wk_d[0].rp  = m_side.rp;
    wk_d[0].e   = m_side.e;
    ang_t = {1'b0, m_rem} - {1'b0, ph_red_q};
    if (ang_t[19]) begin
      ang_t = ang_t + 20'(Q16_TWO_PI);
    end
    wk_d[0].ang = ang_t[18:0];
    ec = (m_side.e >= 35'(E_CAP)) ? 21'(E_CAP) : m_side.e[20:0];
    p_y = 38'(ec) * 38'(Q16_LOG2E);
    wk_d[0].y = p_y[37:16];

    // F2: quadrant fold; split y into shift and fraction
    wk_d[1] = wk_q[0];
    a = wk_q[0].ang;
    wk_d[1].neg = 1'b0;
    if (a >= 19'(Q16_PI)) begin
      a = a - 19'(Q16_PI);
      wk_d[1].neg = 1'b1;
    end
    if (a > 19'(Q16_HALF_PI)) begin
      a = 19'(Q16_PI) - a;
    end
    wk_d[1].x = a[16:0];
    wk_d[1].n = wk_q[0].y[21:16];
    p_z = 32'(wk_q[0].y[15:0]) * 32'(Q16_LN2);
    wk_d[1].z = p_z[31:16];

    // F3
    wk_d[2] = wk_q[1];
    p_xx = 34'(wk_q[1].x) * 34'(wk_q[1].x);
    wk_d[2].x2 = p_xx[33:16];
    p_c16 = 34'(wk_q[1].z) * 34'(RCP6_F);
    wk_d[2].tf = one_minus(18'(p_c16 >> SH6_F));

    // F4
    wk_d[3] = wk_q[2];
    p_c18 = 37'(wk_q[2].x2) * 37'(RCP42_S);
    wk_d[3].ts = one_minus(18'(p_c18 >> SH42_S));
    wk_d[3].pf = 16'(mul_q16(18'(wk_q[2].z), wk_q[2].tf));

    // F5
    wk_d[4] = wk_q[3];
    wk_d[4].ps = mul_q16(wk_q[3].x2, wk_q[3].ts);
    p_c16 = 34'(wk_q[3].pf) * 34'(RCP5_F);
    wk_d[4].tf = one_minus(18'(p_c16 >> SH5_F));

    // F6
    wk_d[5] = wk_q[4];
    p_c18 = 37'(wk_q[4].ps) * 37'(RCP20_S);
    wk_d[5].ts = one_minus(18'(p_c18 >> SH20_S));
    wk_d[5].pf = 16'(mul_q16(18'(wk_q[4].z), wk_q[4].tf));

    // F7
    wk_d[6] = wk_q[5];
    wk_d[6].ps = mul_q16(wk_q[5].x2, wk_q[5].ts);
    wk_d[6].tf = one_minus(18'(wk_q[5].pf >> 2));

    // F8
    wk_d[7] = wk_q[6];
    p_c18 = 37'(wk_q[6].ps) * 37'(RCP6_S);
    wk_d[7].ts = one_minus(18'(p_c18 >> SH6_S));
    wk_d[7].pf = 16'(mul_q16(18'(wk_q[6].z), wk_q[6].tf));

    // F9: sine magnitude done
    wk_d[8] = wk_q[7];
    p_xs = 34'(wk_q[7].x) * 34'(wk_q[7].ts);
    wk_d[8].s = p_xs[32:16];
    p_c16 = 34'(wk_q[7].pf) * 34'(RCP3_F);
    wk_d[8].tf = one_minus(18'(p_c16 >> SH3_F));

    // F10
    wk_d[9] = wk_q[8];
    wk_d[9].pf = 16'(mul_q16(18'(wk_q[8].z), wk_q[8].tf));

    // F11
    wk_d[10] = wk_q[9];
    wk_d[10].tf = one_minus(18'(wk_q[9].pf >> 1));

    // F12
    wk_d[11] = wk_q[10];
    wk_d[11].pf = 16'(mul_q16(18'(wk_q[10].z), wk_q[10].tf));

    // F13: last term, then 2^-n
    wk_d[12] = wk_q[11];
    t_end = one_minus(18'(wk_q[11].pf));
    wk_d[12].mf = (wk_q[11].n >= 6'(FADE_NMAX)) ? '0 : t_end >> wk_q[11].n;

    // F14
    wk_d[13] = wk_q[12];
    wk_d[13].amp_s = 34'(amp_q) * 34'(wk_q[12].s);

    // F15
    wk_d[14] = wk_q[13];
    p_d = 51'(wk_q[13].amp_s) * 51'(wk_q[13].mf);
    wk_d[14].disp = p_d[48:32];

    // F16: numerators of the direction scaling
    wk_d[15] = wk_q[14];
    wk_d[15].numx = 38'(wk_q[14].geo.dx_mag) * 38'(wk_q[14].disp);
    wk_d[15].numy = 38'(wk_q[14].geo.dy_mag) * 38'(wk_q[14].disp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wk_vld_q <= '0;
    end else begin
      wk_vld_q <= {wk_vld_q[FN-2:0], m_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < FN; k++) begin
      wk_q[k] <= wk_d[k];
    end
  end

  // ---------------- offset = |d| * disp / rp ----------------
  work_t  wl;
  coord_t xs_in, ys_in, xs_out, ys_out;
  logic   x_vld;
  logic [16:0] x_off, y_off;

  assign wl = wk_q[FN-1];

  always_comb begin
    xs_in.pix  = wl.geo.px;
    xs_in.flip = wl.geo.dx_neg ^ wl.neg;
    xs_in.zero = (wl.rp == '0);
    ys_in.pix  = wl.geo.py;
    ys_in.flip = wl.geo.dy_neg ^ wl.neg;
    ys_in.zero = (wl.rp == '0);
  end

  rrcw_div #(
    .DW (38),
    .VW (RP_W),
    .QW (17),
    .SW ($bits(coord_t))
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (wk_vld_q[FN-1]),
    .dividend_i (wl.numx),
    .divisor_i  (wl.rp),
    .side_i     (xs_in),
    .vld_o      (x_vld),
    .quot_o     (x_off),
    .rem_o      (),
    .side_o     (xs_out)
  );

  rrcw_div #(
    .DW (38),
    .VW (RP_W),
    .QW (17),
    .SW ($bits(coord_t))
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (wk_vld_q[FN-1]),
    .dividend_i (wl.numy),
    .divisor_i  (wl.rp),
    .side_i     (ys_in),
    .vld_o      (),
    .quot_o     (y_off),
    .rem_o      (),
    .side_o     (ys_out)
  );

  // ---------------- output: apply offset, saturate ----------------
  function automatic logic [OUT_W-1:0] place(coord_t c, logic [16:0] off);
    logic signed [OUT_W:0] v;
    v = signed'((OUT_W+1)'({c.pix, {FRAC_BITS{1'b0}}}));
    if (!c.zero) begin
      if (c.flip) begin
        v = v - signed'((OUT_W+1)'(off));
      end else begin
        v = v + signed'((OUT_W+1)'(off));
      end
    end
    if (v < (OUT_W+1)'(OUT_LOW)) begin
      v = (OUT_W+1)'(OUT_LOW);
    end
    if (v > (OUT_W+1)'(OUT_HIGH)) begin
      v = (OUT_W+1)'(OUT_HIGH);
    end
    return v[OUT_W-1:0];
  endfunction

  logic             out_vld_q;
  logic [OUT_W-1:0] src_x_q, src_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= x_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    src_x_q <= place(xs_out, x_off);
    src_y_q <= place(ys_out, y_off);
  end

  assign result_valid_o = out_vld_q;
  assign source_x_o     = signed'(src_x_q);
  assign source_y_o     = signed'(src_y_q);

endmodule

// ===== bench/tb_radial_ripple_coordinate_warp_core.sv =====
// Testbench for radial_ripple_coordinate_warp_core: random and directed pixel beats,
// register writes between phases, results checked against a built-in fixed-point predictor.
// Depends on rrcw_pkg and the core RTL.
module tb_radial_ripple_coordinate_warp_core
  import rrcw_pkg::*;
();

  localparam int LATENCY = 52;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
  } src_coord_t;

  // register copy held by the predictor
  longint unsigned cx_q, cy_q, ihw_q, amp_q, freq_q, phase_q, decay_q;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sine_mag(longint a, output bit neg);
    longint unsigned x, x2, t;
    neg = 0;
    if (a >= Q16_PI) begin
      a -= Q16_PI;
      neg = 1;
    end
    if (a > Q16_HALF_PI) a = Q16_PI - a;
    x = a;
    x2 = (x * x) >> 16;
    t = 65536 - x2 / 42;
    t = 65536 - ((x2 * t) >> 16) / 20;
    t = 65536 - ((x2 * t) >> 16) / 6;
    return (x * t) >> 16;
  endfunction

  function automatic longint unsigned fade(longint unsigned e);
    longint unsigned y, n, z, t;
    y = (e * Q16_LOG2E) >> 16;
    n = y >> 16;
    t = 65536;
    if (n >= FADE_NMAX) return 0;
    z = ((y & 64'hFFFF) * Q16_LN2) >> 16;
    for (int k = 6; k >= 1; k--) t = 65536 - ((z * t) >> 16) / k;
    return t >> n;
  endfunction

  function automatic logic signed [OUT_W-1:0] place(longint unsigned pix, longint d,
                                                   longint unsigned disp, bit neg,
                                                   longint unsigned rp);
    longint v, off;
    longint unsigned mag;
    v = longint'(pix << FRAC_BITS);
    if (rp != 0) begin
      mag = (d < 0) ? -d : d;
      off = (mag * disp) / rp;
      if ((d < 0) != neg) off = -off;
      v += off;
    end
    if (v < OUT_LOW) v = OUT_LOW;
    if (v > OUT_HIGH) v = OUT_HIGH;
    return v[OUT_W-1:0];
  endfunction

  function automatic src_coord_t warp_pixel(logic [PIX_W-1:0] pxi, logic [PIX_W-1:0] pyi);
    longint unsigned px, py, rp, r, s, m, disp;
    longint dx, dy, ang;
    bit neg;
    src_coord_t res;
    px = pxi;
    py = pyi;
    if (px > MAX_DIM - 1) px = MAX_DIM - 1;
    if (py > MAX_DIM - 1) py = MAX_DIM - 1;
    dx = longint'(px << FRAC_BITS) + PIX_HALF - longint'(cx_q);
    dy = longint'(py << FRAC_BITS) + PIX_HALF - longint'(cy_q);
    rp = int_sqrt(longint'(dx * dx) + longint'(dy * dy));
    r = (rp * ihw_q) >> (FRAC_BITS + 8);
    ang = longint'((freq_q * r) >> 8) - longint'(phase_q);
    ang = ang % Q16_TWO_PI;
    if (ang < 0) ang += Q16_TWO_PI;
    s = sine_mag(ang, neg);
    m = fade((decay_q * r) >> 8);
    disp = (amp_q * s * m) >> 32;
    res.sx = place(px, dx, disp, neg, rp);
    res.sy = place(py, dy, disp, neg, rp);
    return res;
  endfunction

  class warp_scoreboard;
    src_coord_t pending[$];
    int mismatches;
    int checked;

    function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
      pending.insert(pending.size(), warp_pixel(px, py));
    endfunction

    function void check_coord(logic signed [OUT_W-1:0] sx, logic signed [OUT_W-1:0] sy);
      src_coord_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: x=%0d y=%0d", sx, sy);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.sx !== sx || want.sy !== sy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: expected x=%0d y=%0d, got x=%0d y=%0d",
                   checked, want.sx, want.sy, sx, sy);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  logic [PIX_W-1:0] pixel_x_i = '0;
  logic [PIX_W-1:0] pixel_y_i = '0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [25:0] cfg_data_i = '0;
  logic result_valid_o;
  logic signed [OUT_W-1:0] source_x_o;
  logic signed [OUT_W-1:0] source_y_o;

  warp_scoreboard sb = new();
  longint cycles = 0;
  int pixels_sent = 0;
  int cfg_writes = 0;

  radial_ripple_coordinate_warp_core uut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (result_valid_o) sb.check_coord(source_x_o, source_y_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("radial_ripple_coordinate_warp_core verification failed");
      $finish;
    end
  end

  // one pixel beat, after an optional gap; returns at the falling edge after acceptance
  task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1;
    pixel_x_i <= px;
    pixel_y_i <= py;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(px, py);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  // valid drops for one cycle after each beat, so back-to-back calls never collide
  task automatic write_reg(cfg_reg_e idx, longint unsigned val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val[25:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CENTER_X:   cx_q = val & 21'h1FFFFF;
      REG_CENTER_Y:   cy_q = val & 21'h1FFFFF;
      REG_INV_HALF:   ihw_q = val & 26'h3FFFFFF;
      REG_AMP:        amp_q = val & 17'h1FFFF;
      REG_FREQUENCY:  freq_q = val & 14'h3FFF;
      REG_RING_PHASE: phase_q = val & 19'h7FFFF;
      REG_DECAY_RATE: decay_q = val & 11'h7FF;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 0;
    @(negedge clk_i);
  endtask

  task automatic load_setting(longint unsigned cx, longint unsigned cy, longint unsigned ihw,
                              longint unsigned amp, longint unsigned fr,
                              longint unsigned ph, longint unsigned dc);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_INV_HALF, ihw);
    write_reg(REG_AMP, amp);
    write_reg(REG_FREQUENCY, fr);
    write_reg(REG_RING_PHASE, ph);
    write_reg(REG_DECAY_RATE, dc);
  endtask

  // pixels clustered near the center most of the time, so the ripple is strong
  task automatic random_phase(int count);
    logic [PIX_W-1:0] px, py;
    int burst;
    for (int i = 0; i < count; i++) begin
      burst = $urandom_range(0, 3);
      if (burst == 0) begin
        px = PIX_W'($urandom);
        py = PIX_W'($urandom);
      end else begin
        px = PIX_W'((cx_q >> FRAC_BITS) + $urandom_range(0, 400) - 200);
        py = PIX_W'((cy_q >> FRAC_BITS) + $urandom_range(0, 400) - 200);
      end
      send_pixel(px, py, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    cx_q = RST_CENTER_X;  cy_q = RST_CENTER_Y;  ihw_q = RST_INV_HALF;
    amp_q = RST_AMP;  freq_q = RST_FREQUENCY;  phase_q = RST_PHASE;  decay_q = RST_DECAY;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // directed: field extremes and near-zero radius at reset settings
    send_pixel(0, 0, 0);
    send_pixel(13'h1FFF, 13'h1FFF, 0);
    send_pixel(8191, 0, 0);
    send_pixel(0, 8191, 0);
    send_pixel(4095, 4095, 0);       // center 1048576 = 4096*256, so near zero radius
    send_pixel(4096, 4096, 0);
    send_pixel(4000, 4200, 0);
    send_pixel(13'h1AAA, 13'h0555, 0);
    send_pixel(13'h0555, 13'h1AAA, 0);
    drain();
    // exact zero radius: center on a pixel center
    load_setting(100 * 256 + 128, 200 * 256 + 128, 33554432, 131071, 10240, 0, 0);
    send_pixel(100, 200, 0);
    send_pixel(101, 200, 0);
    send_pixel(100, 199, 0);
    send_pixel(0, 0, 0);
    send_pixel(8191, 8191, 0);
    drain();
    // zero inverse width, out-of-range phase and register maxima
    load_setting(2097151, 0, 0, 131071, 16383, 524287, 2047);
    send_pixel(8191, 0, 0);
    send_pixel(0, 8191, 0);
    send_pixel(8000, 10, 0);
    drain();
    load_setting(0, 2097151, 67108863, 0, 256, 411774, 1024);
    send_pixel(0, 8191, 0);
    send_pixel(5, 8100, 0);
    drain();

    // random phases across several settings
    load_setting(RST_CENTER_X, RST_CENTER_Y, RST_INV_HALF, RST_AMP, RST_FREQUENCY,
                 RST_PHASE, RST_DECAY);
    random_phase(150);
    drain();
    for (int p = 0; p < 4; p++) begin
      load_setting($urandom_range(0, 2097151), $urandom_range(0, 2097151),
                   $urandom_range(0, 33554432), $urandom_range(0, 131071),
                   $urandom_range(256, 10240), $urandom_range(0, 411774),
                   $urandom_range(0, 1024));
      if (p == 1) write_reg(REG_INV_HALF, $urandom_range(40000, 400000));
      random_phase(95);
      drain();
    end

    $display("covered %0d pixel beats and %0d register writes, %0d results checked",
             pixels_sent, cfg_writes, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("radial_ripple_coordinate_warp_core verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("radial_ripple_coordinate_warp_core verification failed");
    end
    $finish;
  end

endmodule
